// File: rtl/urh_pkg.sv
package urh_pkg;

  localparam int unsigned URH_DEPTH = 64;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned ENTRY_W   = 48;
  localparam int unsigned ANNOT_W   = 8;

  localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BACK     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FORWARD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRUNCATE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_AMEND    = 3'd5;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

// File: rtl/urh_ctrl.sv
module urh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              resp_valid,
  output urh_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign resp_valid  = (state_r == ST_RESP);
  assign cmd.capture = (state_r == ST_IDLE) && start;
  assign cmd.exec    = (state_r == ST_EXEC);

endmodule

// File: rtl/urh_dp.sv
module urh_dp #(
  parameter int unsigned DEPTH = urh_pkg::URH_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  urh_pkg::dp_cmd_t            cmd,
  input  logic [urh_pkg::MODE_W-1:0]  in_mode,
  input  logic [urh_pkg::ENTRY_W-1:0] in_entry_word,
  input  logic [urh_pkg::ANNOT_W-1:0] in_annotation,
  output logic                        found,
  output logic [urh_pkg::ENTRY_W-1:0] entry_out,
  output logic [urh_pkg::ANNOT_W-1:0] annotation_out,
  output logic                        at_start,
  output logic                        at_end
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [urh_pkg::ENTRY_W-1:0] pay_mem [DEPTH];
  logic [urh_pkg::ANNOT_W-1:0] ann_mem [DEPTH];

  logic [urh_pkg::MODE_W-1:0]  mode_r;
  logic [urh_pkg::ENTRY_W-1:0] entry_r;
  logic [urh_pkg::ANNOT_W-1:0] annot_r;

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [AW-1:0] newest_r, newest_nxt;
  logic [AW-1:0] cursor_r, cursor_nxt;
  logic          empty_r, empty_nxt;
  logic          found_r, found_nxt;

  logic [urh_pkg::ENTRY_W-1:0] rd_pay_r;
  logic [urh_pkg::ANNOT_W-1:0] rd_ann_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_pay;
  logic          wr_ann;
  logic [AW-1:0] cur_next;
  logic [AW-1:0] cur_prev;
  logic [AW-1:0] push_slot_next;
  logic [AW-1:0] old_base;
  logic [AW-1:0] old_next;

  assign cur_next = (cursor_r == LAST) ? '0 : cursor_r + AW'(1);
  assign cur_prev = (cursor_r == '0) ? LAST : cursor_r - AW'(1);
  assign push_slot_next = (cur_next == LAST) ? '0 : cur_next + AW'(1);
  assign old_base = empty_r ? '0 : oldest_r;
  assign old_next = (old_base == LAST) ? '0 : old_base + AW'(1);

  always_comb begin
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    cursor_nxt = cursor_r;
    empty_nxt  = empty_r;
    found_nxt  = 1'b0;
    rd_addr    = cursor_r;
    wr_addr    = cursor_r;
    wr_pay     = 1'b0;
    wr_ann     = 1'b0;
    case (mode_r)
      urh_pkg::MODE_PUSH: begin
        empty_nxt  = 1'b0;
        cursor_nxt = cur_next;
        newest_nxt = cur_next;
        wr_addr    = cur_next;
        wr_pay     = 1'b1;
        wr_ann     = 1'b1;
        oldest_nxt = (push_slot_next == old_base) ? old_next : old_base;
      end
      urh_pkg::MODE_BACK: begin
        if (!empty_r && cur_next != oldest_r) begin
          found_nxt  = 1'b1;
          rd_addr    = cursor_r;
          cursor_nxt = cur_prev;
        end
      end
      urh_pkg::MODE_FORWARD: begin
        if (!empty_r && cursor_r != newest_r) begin
          found_nxt  = 1'b1;
          rd_addr    = cur_next;
          cursor_nxt = cur_next;
        end
      end
      urh_pkg::MODE_CLEAR: begin
        oldest_nxt = '0;
        newest_nxt = LAST;
        cursor_nxt = LAST;
        empty_nxt  = 1'b1;
      end
      urh_pkg::MODE_TRUNCATE: begin
        newest_nxt = cursor_r;
      end
      urh_pkg::MODE_AMEND: begin
        wr_ann = !empty_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      entry_r <= in_entry_word;
      annot_r <= in_annotation;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      newest_r <= LAST;
      cursor_r <= LAST;
      empty_r  <= 1'b1;
      found_r  <= 1'b0;
    end else if (cmd.exec) begin
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      cursor_r <= cursor_nxt;
      empty_r  <= empty_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_pay) pay_mem[wr_addr] <= entry_r;
    if (cmd.exec && wr_ann) ann_mem[wr_addr] <= annot_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_pay_r <= pay_mem[rd_addr];
      rd_ann_r <= ann_mem[rd_addr];
    end
  end

  assign found          = found_r;
  assign entry_out      = found_r ? rd_pay_r : '0;
  assign annotation_out = found_r ? rd_ann_r : '0;
  assign at_start       = empty_r || (cur_next == oldest_r);
  assign at_end         = (cursor_r == newest_r);

endmodule

// File: rtl/undo_redo_history_ring.sv
// Undo/redo history ring. Each transaction passes through the accept
// edge, the pointer update with the access to the history memory, and
// the result cycle in which out_valid is high. The receiver cannot
// stall: out_valid is high for exactly one cycle per result, and busy
// stays high through the pointer update and the result cycle, so the next
// transaction can be taken the cycle after the result.
module undo_redo_history_ring #(
  parameter int unsigned DEPTH = urh_pkg::URH_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [urh_pkg::MODE_W-1:0]  in_mode,
  input  logic [urh_pkg::ENTRY_W-1:0] in_entry_word,
  input  logic [urh_pkg::ANNOT_W-1:0] in_annotation,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [urh_pkg::ENTRY_W-1:0] out_entry_out,
  output logic [urh_pkg::ANNOT_W-1:0] out_annotation_out,
  output logic                        out_at_start,
  output logic                        out_at_end
);

  urh_pkg::dp_cmd_t cmd;

  urh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .resp_valid (out_valid),
    .cmd        (cmd)
  );

  urh_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_entry_word  (in_entry_word),
    .in_annotation  (in_annotation),
    .found          (out_found),
    .entry_out      (out_entry_out),
    .annotation_out (out_annotation_out),
    .at_start       (out_at_start),
    .at_end         (out_at_end)
  );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

  localparam logic [urh_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [urh_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam int TARGET_OPS  = 1550;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_GAP     = 12;

  typedef struct {
    logic [urh_pkg::MODE_W-1:0]  mode;
    logic [urh_pkg::ENTRY_W-1:0] entry;
    logic [urh_pkg::ANNOT_W-1:0] annot;
    bit                          hold_until_idle;
  } hist_op_t;

  typedef struct {
    logic                        found;
    logic [urh_pkg::ENTRY_W-1:0] entry;
    logic [urh_pkg::ANNOT_W-1:0] annot;
    logic                        at_start;
    logic                        at_end;
  } ring_reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [urh_pkg::MODE_W-1:0]  in_mode = urh_pkg::MODE_CLEAR;
  logic [urh_pkg::ENTRY_W-1:0] in_entry_word = '0;
  logic [urh_pkg::ANNOT_W-1:0] in_annotation = '0;
  logic                        out_valid;
  logic                        out_found;
  logic [urh_pkg::ENTRY_W-1:0] out_entry_out;
  logic [urh_pkg::ANNOT_W-1:0] out_annotation_out;
  logic                        out_at_start;
  logic                        out_at_end;

  hist_op_t    op_queue[$];
  ring_reply_t replies_due[$];
  int          err_count = 0;
  int          stall_cycles = 0;
  int          ops_made = 0;
  int          gap_left = 0;
  bit          calm = 1'b0;
  logic        op_taken = 1'b0;

  logic [urh_pkg::ENTRY_W-1:0] shadow_entry[urh_pkg::URH_DEPTH];
  logic [urh_pkg::ANNOT_W-1:0] shadow_annot[urh_pkg::URH_DEPTH];
  int unsigned                 oldest_slot;
  int unsigned                 newest_slot;
  int unsigned                 cursor_slot;
  bit                          ring_is_empty;

  undo_redo_history_ring dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_entry_word      (in_entry_word),
    .in_annotation      (in_annotation),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_entry_out      (out_entry_out),
    .out_annotation_out (out_annotation_out),
    .out_at_start       (out_at_start),
    .out_at_end         (out_at_end)
  );

  always #2 clk = ~clk;

  function automatic int unsigned slot_after(int unsigned i);
    return (i + 1) % urh_pkg::URH_DEPTH;
  endfunction

  function automatic int unsigned slot_before(int unsigned i);
    return (i == 0) ? urh_pkg::URH_DEPTH - 1 : i - 1;
  endfunction

  function automatic void clear_history_pointers();
    oldest_slot   = 0;
    newest_slot   = urh_pkg::URH_DEPTH - 1;
    cursor_slot   = urh_pkg::URH_DEPTH - 1;
    ring_is_empty = 1'b1;
  endfunction

  function automatic ring_reply_t step_history(hist_op_t op);
    ring_reply_t r;
    r.found = 1'b0;
    r.entry = '0;
    r.annot = '0;
    case (op.mode)
      urh_pkg::MODE_PUSH: begin
        if (ring_is_empty) begin
          oldest_slot   = 0;
          ring_is_empty = 1'b0;
        end
        cursor_slot = slot_after(cursor_slot);
        shadow_entry[cursor_slot] = op.entry;
        shadow_annot[cursor_slot] = op.annot;
        newest_slot = cursor_slot;
        if (slot_after(newest_slot) == oldest_slot) oldest_slot = slot_after(oldest_slot);
      end
      urh_pkg::MODE_BACK: begin
        if (!ring_is_empty && slot_after(cursor_slot) != oldest_slot) begin
          r.found = 1'b1;
          r.entry = shadow_entry[cursor_slot];
          r.annot = shadow_annot[cursor_slot];
          cursor_slot = slot_before(cursor_slot);
        end
      end
      urh_pkg::MODE_FORWARD: begin
        if (!ring_is_empty && cursor_slot != newest_slot) begin
          cursor_slot = slot_after(cursor_slot);
          r.found = 1'b1;
          r.entry = shadow_entry[cursor_slot];
          r.annot = shadow_annot[cursor_slot];
        end
      end
      urh_pkg::MODE_CLEAR: clear_history_pointers();
      urh_pkg::MODE_TRUNCATE: newest_slot = cursor_slot;
      urh_pkg::MODE_AMEND: begin
        if (!ring_is_empty) shadow_annot[cursor_slot] = op.annot;
      end
      default: ;
    endcase
    r.at_start = ring_is_empty || (slot_after(cursor_slot) == oldest_slot);
    r.at_end   = (cursor_slot == newest_slot);
    return r;
  endfunction

  function automatic logic [urh_pkg::ENTRY_W-1:0] rand_entry();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 15))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    return w[urh_pkg::ENTRY_W-1:0];
  endfunction

  task automatic add_op(logic [urh_pkg::MODE_W-1:0] mode,
                        logic [urh_pkg::ENTRY_W-1:0] entry,
                        logic [urh_pkg::ANNOT_W-1:0] annot);
    hist_op_t op;
    op.mode  = mode;
    op.entry = entry;
    op.annot = annot;
    op.hold_until_idle = (ops_made % 500 == 30);
    op_queue.push_back(op);
    if (mode != MODE_SPARE_6 && mode != MODE_SPARE_7) ops_made++;
  endtask

  task automatic add_random_op();
    int p;
    logic [urh_pkg::MODE_W-1:0] mode;
    p = $urandom_range(0, 99);
    if (p < 35) mode = urh_pkg::MODE_PUSH;
    else if (p < 55) mode = urh_pkg::MODE_BACK;
    else if (p < 75) mode = urh_pkg::MODE_FORWARD;
    else if (p < 77) mode = urh_pkg::MODE_CLEAR;
    else if (p < 85) mode = urh_pkg::MODE_TRUNCATE;
    else if (p < 95) mode = urh_pkg::MODE_AMEND;
    else mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
    add_op(mode, rand_entry(), 8'($urandom_range(0, 255)));
  endtask

  task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
    err_count++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
  endtask

  initial begin
    int kind;
    int n;
    clear_history_pointers();

    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_FORWARD, '0, '0);
    add_op(urh_pkg::MODE_AMEND, '0, 8'hAA);
    add_op(urh_pkg::MODE_TRUNCATE, '0, '0);
    add_op(MODE_SPARE_6, '1, '1);
    add_op(MODE_SPARE_7, '0, '0);
    add_op(urh_pkg::MODE_PUSH, '1, 8'hFF);
    add_op(urh_pkg::MODE_PUSH, '0, 8'h00);
    add_op(urh_pkg::MODE_PUSH, 48'h5555_5555_5555, 8'h5A);
    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_AMEND, '0, 8'h3C);
    add_op(urh_pkg::MODE_FORWARD, '0, '0);
    add_op(urh_pkg::MODE_AMEND, '0, 8'hC3);
    add_op(urh_pkg::MODE_FORWARD, '0, '0);
    add_op(urh_pkg::MODE_TRUNCATE, '0, '0);
    add_op(urh_pkg::MODE_FORWARD, '0, '0);
    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_PUSH, 48'hAAAA_AAAA_AAAA, 8'hA5);
    add_op(MODE_SPARE_7, '1, '1);
    add_op(urh_pkg::MODE_CLEAR, '0, '0);
    add_op(urh_pkg::MODE_BACK, '0, '0);
    add_op(urh_pkg::MODE_PUSH, rand_entry(), 8'($urandom_range(0, 255)));

    while (ops_made < TARGET_OPS) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        n = $urandom_range(20, 80);
        repeat (n) add_op(urh_pkg::MODE_PUSH, rand_entry(), 8'($urandom_range(0, 255)));
      end else if (kind == 2) begin
        n = $urandom_range(1, 70);
        repeat (n) add_op(urh_pkg::MODE_BACK, rand_entry(), 8'($urandom_range(0, 255)));
      end else if (kind == 3) begin
        n = $urandom_range(1, 70);
        repeat (n) add_op(urh_pkg::MODE_FORWARD, rand_entry(), 8'($urandom_range(0, 255)));
      end else begin
        repeat (12) add_random_op();
      end
    end
  end

  always @(negedge clk) begin
    hist_op_t op;
    if (rst_n) begin
      if (start) begin
        if (op_taken) begin
          start <= 1'b0;
          if ($urandom_range(0, 15) == 0) calm = !calm;
          gap_left <= calm ? 0 : $urandom_range(0, MAX_GAP);
        end
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (op_queue.size() != 0 &&
                   (!op_queue[0].hold_until_idle || (replies_due.size() == 0 && !busy))) begin
        op = op_queue.pop_front();
        in_mode       <= op.mode;
        in_entry_word <= op.entry;
        in_annotation <= op.annot;
        start         <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    hist_op_t    taken;
    ring_reply_t want;
    if (!rst_n) begin
      op_taken <= 1'b0;
    end else begin
      op_taken <= start && !busy;
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: found %0b entry %0h annotation %0h",
                   $time, out_found, out_entry_out, out_annotation_out);
        end else begin
          want = replies_due.pop_front();
          if (out_found !== want.found) report_field("found", want.found, out_found);
          if (out_entry_out !== want.entry) report_field("entry_out", want.entry, out_entry_out);
          if (out_annotation_out !== want.annot)
            report_field("annotation_out", want.annot, out_annotation_out);
          if (out_at_start !== want.at_start)
            report_field("at_start", want.at_start, out_at_start);
          if (out_at_end !== want.at_end) report_field("at_end", want.at_end, out_at_end);
        end
      end
      if (start && !busy) begin
        taken.mode  = in_mode;
        taken.entry = in_entry_word;
        taken.annot = in_annotation;
        taken.hold_until_idle = 1'b0;
        replies_due.push_back(step_history(taken));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);
    while (op_queue.size() != 0 || start || replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
